// ----- rtl/pdas_pkg.sv -----
// shared constants, register indexes and types for the pd angle controller
package pdas_pkg;

    localparam int POS_BITS    = 24;
    localparam int FRAC_BITS   = 4;
    localparam int SCALE_SHIFT = 16;

    localparam int TARGET_W = 13;
    localparam int GAIN_W   = 10;
    localparam int SLEW_W   = 11;
    localparam int LIMIT_W  = 7;
    localparam int SCALE_W  = 18;
    localparam int DRIVE_W  = 8;
    localparam int ERR_W    = 13;
    localparam int POWER_W  = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // shared multiplier and angle widths
    localparam int SUM_W   = POS_BITS + 1;
    localparam int MUL_A_W = SUM_W;
    localparam int MUL_B_W = SCALE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ANG_W   = PROD_W - SCALE_SHIFT;
    localparam int MAG_W   = POS_BITS + 3;

    // modulo reducer: a full turn is TURN_ODD shifted up by LO_W bits
    localparam int     LO_W        = FRAC_BITS + 3;
    localparam int     TURN_ODD    = 45;
    localparam int     HI_W        = MAG_W - LO_W;
    localparam int     ODD_W       = 6;
    localparam int     RECIP_SHIFT = HI_W + ODD_W;
    localparam int     RECIP_W     = RECIP_SHIFT - 5;
    localparam int     RPROD_W     = HI_W + RECIP_W;
    localparam int     QUOT_W      = RPROD_W - RECIP_SHIFT;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + TURN_ODD - 1) / TURN_ODD;
    localparam int     REM_W       = ERR_W;

    localparam int FULL_TURN = 360 << FRAC_BITS;
    localparam int HALF_TURN = 180 << FRAC_BITS;
    localparam logic [REM_W:0] FULL_TURN_R = (REM_W + 1)'(FULL_TURN);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_ANGLE = 3'd0,
        REG_PROP_GAIN    = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_SLEW_STEP    = 3'd3,
        REG_POWER_LIMIT  = 3'd4,
        REG_COUNTS_SCALE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target_angle;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [SLEW_W-1:0]   slew_step;
        logic [LIMIT_W-1:0]  power_limit;
        logic [SCALE_W-1:0]  counts_scale;
    } cfg_t;

endpackage

// ----- rtl/pdas_in_if.sv -----
// input channel: two encoder positions per word
interface pdas_in_if import pdas_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] pos_first;
    logic signed [POS_BITS-1:0] pos_second;

    modport source (output valid, output pos_first, output pos_second, input ready);
    modport sink (input valid, input pos_first, input pos_second, output ready);

endinterface

// ----- rtl/pdas_out_if.sv -----
// output channel: drive command and wrapped angle error per word
interface pdas_out_if import pdas_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   angle_error;

    modport source (output valid, output drive, output angle_error, input ready);
    modport sink (input valid, input drive, input angle_error, output ready);

endinterface

// ----- rtl/pdas_front.sv -----
// front end: accepts position words, sums the encoders, hands sums to the queue
module pdas_front import pdas_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    pdas_in_if.sink                 sample,
    input  logic                    full,
    output logic                    push,
    output logic signed [SUM_W-1:0] push_data
);

    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    accept;

    assign push         = hold_valid_reg && !full;
    assign sample.ready = !hold_valid_reg || !full;
    assign accept       = sample.valid && sample.ready;
    assign push_data    = sum_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= {sample.pos_first[POS_BITS-1], sample.pos_first}
                     + {sample.pos_second[POS_BITS-1], sample.pos_second};
        end
    end

endmodule

// ----- rtl/pdas_fifo.sv -----
// two-entry queue of encoder sums between front and back
module pdas_fifo import pdas_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic signed [SUM_W-1:0] push_data,
    output logic                    full,
    input  logic                    pop,
    output logic signed [SUM_W-1:0] pop_data,
    output logic                    empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [SUM_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/pdas_modred.sv -----
// floor modulo of the arm angle by a full turn, by reciprocal multiply
module pdas_modred import pdas_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] value,
    output logic                    done,
    output logic [REM_W-1:0]        result
);

    localparam logic [RECIP_W-1:0] RECIP_R    = RECIP_W'(RECIP);
    localparam logic [HI_W-1:0]    TURN_ODD_H = HI_W'(TURN_ODD);

    logic               mul_pend_reg;
    logic               fold_pend_reg;
    logic               done_reg;
    logic               neg_reg;
    logic [LO_W-1:0]    lo_reg;
    logic [HI_W-1:0]    hi_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [ANG_W-1:0]   abs_val;
    logic [RPROD_W-1:0] recip_prod;
    logic [HI_W-1:0]    hi_fold;

    assign abs_val    = value[ANG_W-1] ? ANG_W'(-value) : ANG_W'(value);
    assign recip_prod = RPROD_W'(hi_reg) * RPROD_W'(RECIP_R);
    // low bits pass through, the high part is reduced by the odd factor
    assign hi_fold    = hi_reg - HI_W'(quot_reg) * TURN_ODD_H;
    assign rem_next   = REM_W'({hi_fold[ODD_W-1:0], lo_reg});
    assign done       = done_reg;
    assign result     = (neg_reg && rem_reg != '0)
                      ? REM_W'(FULL_TURN_R - {1'b0, rem_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg  <= 1'b0;
            fold_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_pend_reg  <= start;
            fold_pend_reg <= mul_pend_reg;
            done_reg      <= fold_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= value[ANG_W-1];
            lo_reg  <= abs_val[LO_W-1:0];
            hi_reg  <= abs_val[MAG_W-1:LO_W];
        end
        if (mul_pend_reg)
        begin
            quot_reg <= recip_prod[RPROD_W-1:RECIP_SHIFT];
        end
        if (fold_pend_reg)
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- rtl/pdas_back.sv -----
// back end: sequencer with shared multiplier, pd law, slew limit and clamp
module pdas_back import pdas_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    empty,
    output logic                    pop,
    input  logic signed [SUM_W-1:0] pop_data,
    pdas_out_if.source              result
);

    localparam int ERRW_W = TARGET_W + 2;
    localparam int DIFF_W = ERR_W + 1;
    localparam int ACC_W  = 26;
    localparam int RAW_W  = ACC_W - FRAC_BITS;
    localparam int DP_W   = RAW_W + 1;
    localparam int PEXT_W = POWER_W + 1;

    localparam logic signed [ERRW_W-1:0]  HALF_E    = ERRW_W'(HALF_TURN);
    localparam logic signed [ERRW_W-1:0]  FULL_E    = ERRW_W'(FULL_TURN);
    localparam logic signed [ERR_W-1:0]   HALF_ERR  = ERR_W'(HALF_TURN);
    localparam logic signed [POWER_W-1:0] ROUND_ADJ = POWER_W'((1 << FRAC_BITS) - 1);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL_ANG  = 8'b0000_0010,
        ST_MOD_GO   = 8'b0000_0100,
        ST_MOD_WAIT = 8'b0000_1000,
        ST_MUL_P    = 8'b0001_0000,
        ST_MUL_D    = 8'b0010_0000,
        ST_SUM      = 8'b0100_0000,
        ST_SLEW     = 8'b1000_0000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [RAW_W-1:0]   raw_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [POWER_W-1:0] power_reg;
    logic signed [POWER_W-1:0] power_next;
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [ERR_W-1:0]   err_out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mod_start;
    logic                      mod_done;
    logic [REM_W-1:0]          mod_result;
    logic signed [ERRW_W-1:0]  err_wide;
    logic signed [ERRW_W-1:0]  err_wrap;
    logic signed [ERR_W-1:0]   err_new;
    logic signed [DIFF_W-1:0]  diff_new;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [DP_W-1:0]    slew_dp;
    logic signed [DP_W-1:0]    step_dp;
    logic signed [PEXT_W-1:0]  power_ext;
    logic signed [PEXT_W-1:0]  step_p;
    logic signed [PEXT_W-1:0]  lim_p;
    logic signed [PEXT_W-1:0]  slewed;
    logic signed [PEXT_W-1:0]  clamped;
    logic signed [POWER_W-1:0] power_adj;
    logic signed [DRIVE_W-1:0] drive_new;
    logic                      out_free;
    logic                      commit;

    pdas_modred u_modred (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .value  (prod_reg[PROD_W-1:SCALE_SHIFT]),
        .done   (mod_done),
        .result (mod_result)
    );

    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign mod_start = (state_reg == ST_MOD_GO);
    assign out_free  = !out_valid_reg || result.ready;
    assign commit    = (state_reg == ST_SLEW) && out_free;

    assign result.valid       = out_valid_reg;
    assign result.drive       = drive_reg;
    assign result.angle_error = err_out_reg;

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_MUL_P:
            begin
                mul_a = {{(MUL_A_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = MUL_B_W'(cfg.prop_gain);
            end
            ST_MUL_D:
            begin
                mul_a = {{(MUL_A_W - DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = MUL_B_W'(cfg.deriv_gain);
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'(cfg.counts_scale);
            end
        endcase
    end

    // error to target, wrapped to half a turn
    always_comb
    begin
        err_wide = $signed(ERRW_W'(cfg.target_angle)) - $signed(ERRW_W'(mod_result));
        if (err_wide > HALF_E)
        begin
            err_wrap = err_wide - FULL_E;
        end
        else if (err_wide < -HALF_E)
        begin
            err_wrap = err_wide + FULL_E;
        end
        else
        begin
            err_wrap = err_wide;
        end
        err_new  = err_wrap[ERR_W-1:0];
        diff_new = {err_new[ERR_W-1], err_new} - {prev_error_reg[ERR_W-1], prev_error_reg};
    end

    assign acc_sum = acc_reg + prod_reg[ACC_W-1:0];

    // slew toward raw drive, then clamp
    always_comb
    begin
        slew_dp   = {raw_reg[RAW_W-1], raw_reg}
                  - {{(DP_W - POWER_W){power_reg[POWER_W-1]}}, power_reg};
        step_dp   = $signed(DP_W'(cfg.slew_step));
        power_ext = {power_reg[POWER_W-1], power_reg};
        step_p    = $signed(PEXT_W'(cfg.slew_step));
        lim_p     = $signed(PEXT_W'({cfg.power_limit, {FRAC_BITS{1'b0}}}));
        if (slew_dp > step_dp)
        begin
            slewed = power_ext + step_p;
        end
        else if (slew_dp < -step_dp)
        begin
            slewed = power_ext - step_p;
        end
        else
        begin
            slewed = raw_reg[PEXT_W-1:0];
        end
        if (slewed > lim_p)
        begin
            clamped = lim_p;
        end
        else if (slewed < -lim_p)
        begin
            clamped = -lim_p;
        end
        else
        begin
            clamped = slewed;
        end
        power_next = clamped[POWER_W-1:0];
        power_adj  = power_next[POWER_W-1] ? (power_next + ROUND_ADJ) : power_next;
        drive_new  = power_adj[POWER_W-1:FRAC_BITS];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_MUL_ANG;
                end
            end
            ST_MUL_ANG:  state_next = ST_MOD_GO;
            ST_MOD_GO:   state_next = ST_MOD_WAIT;
            ST_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:    state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_SUM;
            ST_SUM:      state_next = ST_SLEW;
            ST_SLEW:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
            power_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg  <= 1'b1;
                prev_error_reg <= err_reg;
                power_reg      <= power_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sum_reg <= pop_data;
        end
        if (state_reg == ST_MUL_ANG || state_reg == ST_MUL_P || state_reg == ST_MUL_D)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_MOD_WAIT && mod_done)
        begin
            err_reg  <= err_new;
            diff_reg <= diff_new;
        end
        if (state_reg == ST_MUL_D)
        begin
            acc_reg <= prod_reg[ACC_W-1:0];
        end
        if (state_reg == ST_SUM)
        begin
            raw_reg <= acc_sum[ACC_W-1:FRAC_BITS];
        end
        if (commit)
        begin
            drive_reg   <= drive_new;
            err_out_reg <= err_reg;
        end
    end

    prev_error_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_error_reg <= HALF_ERR) && (prev_error_reg >= -HALF_ERR))
        else $error("previous error left the half-turn range");

    mod_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD_WAIT))
        else $error("modulo result arrived outside its wait state");

    err_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_P) |-> ((err_reg <= HALF_ERR) && (err_reg >= -HALF_ERR)))
        else $error("wrapped error out of range");

    word_from_slew: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_SLEW))
        else $error("result word raised outside the slew state");

endmodule

// ----- rtl/pd_angle_controller_slew.sv -----
// top level of the pd arm-angle controller with slew limit
//
//  channel   dir  word / fields                         handshake
//  sample    in   pos_first, pos_second (24b signed)    valid / ready
//  result    out  drive (8b signed), angle_error (13b)  valid / ready
//  wr_*      in   wr_index (3b), wr_data (18b)          wr_en, no back-pressure
//
//  each word in the back steps through pop, angle multiply, modulo start, a wait on the
//  reciprocal-multiply modulo, two gain multiplies, sum, then slew and commit
//  a two-entry queue lets the front take words while the back is busy
//  the result register holds a word under back-pressure; the back waits in its last step
//  reset clears control state, pd state and the registers to their defaults
module pd_angle_controller_slew import pdas_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    pdas_in_if.sink               sample,
    pdas_out_if.source            result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    cfg_t                    cfg_reg;
    logic                    push;
    logic signed [SUM_W-1:0] push_data;
    logic                    full;
    logic                    pop;
    logic signed [SUM_W-1:0] pop_data;
    logic                    empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_angle <= TARGET_W'(0);
            cfg_reg.prop_gain    <= GAIN_W'(72);
            cfg_reg.deriv_gain   <= GAIN_W'(96);
            cfg_reg.slew_step    <= SLEW_W'(128);
            cfg_reg.power_limit  <= LIMIT_W'(60);
            cfg_reg.counts_scale <= SCALE_W'(69054);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TARGET_ANGLE: cfg_reg.target_angle <= wr_data[TARGET_W-1:0];
                REG_PROP_GAIN:    cfg_reg.prop_gain    <= wr_data[GAIN_W-1:0];
                REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= wr_data[GAIN_W-1:0];
                REG_SLEW_STEP:    cfg_reg.slew_step    <= wr_data[SLEW_W-1:0];
                REG_POWER_LIMIT:  cfg_reg.power_limit  <= wr_data[LIMIT_W-1:0];
                REG_COUNTS_SCALE: cfg_reg.counts_scale <= wr_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    pdas_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    pdas_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    pdas_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .empty    (empty),
        .pop      (pop),
        .pop_data (pop_data),
        .result   (result)
    );

endmodule

// ----- tb/tb_pd_angle_controller_slew.sv -----
// self-checking testbench for the pd arm-angle controller with slew limit
`timescale 1ns / 100ps

module tb_pd_angle_controller_slew;
    import pdas_pkg::*;

    localparam int PHASE_COUNT = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    localparam cfg_t CFG_AT_RESET = '{
        target_angle: 13'd0,
        prop_gain:    10'd72,
        deriv_gain:   10'd96,
        slew_step:    11'd128,
        power_limit:  7'd60,
        counts_scale: 18'd69054
    };

    typedef struct packed {
        logic signed [POS_BITS-1:0] first;
        logic signed [POS_BITS-1:0] second;
    } pos_pair_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [ERR_W-1:0]   angle_error;
    } ctrl_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    pdas_in_if  sample_ch ();
    pdas_out_if result_ch ();

    pd_angle_controller_slew dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // controller copy
    cfg_t                      ctl_cfg;
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [POWER_W-1:0] power_q;

    pos_pair_t  pos_backlog[$];
    ctrl_word_t due_commands[$];
    pos_pair_t  next_pos;
    ctrl_word_t want;

    logic signed [POS_BITS-1:0] walk_first;
    logic signed [POS_BITS-1:0] walk_second;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    logic hold_req;
    int checked_words;
    int mismatch_count;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_TARGET_ANGLE: ctl_cfg.target_angle = val[TARGET_W-1:0];
            REG_PROP_GAIN:    ctl_cfg.prop_gain    = val[GAIN_W-1:0];
            REG_DERIV_GAIN:   ctl_cfg.deriv_gain   = val[GAIN_W-1:0];
            REG_SLEW_STEP:    ctl_cfg.slew_step    = val[SLEW_W-1:0];
            REG_POWER_LIMIT:  ctl_cfg.power_limit  = val[LIMIT_W-1:0];
            REG_COUNTS_SCALE: ctl_cfg.counts_scale = val[SCALE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_drive(input logic signed [POS_BITS-1:0] p_first,
                                          input logic signed [POS_BITS-1:0] p_second);
        longint sum;
        longint angle;
        longint err;
        longint raw;
        longint gap;
        longint step;
        longint lim;
        longint pwr;
        longint whole;
        ctrl_word_t w;
        sum   = longint'(p_first) + longint'(p_second);
        angle = (sum * longint'(ctl_cfg.counts_scale)) >>> SCALE_SHIFT;
        angle = angle % FULL_TURN;
        if (angle < 0)
            angle = angle + FULL_TURN;
        err = longint'(ctl_cfg.target_angle) - angle;
        while (err > HALF_TURN)
            err = err - FULL_TURN;
        while (err < -HALF_TURN)
            err = err + FULL_TURN;
        raw = (longint'(ctl_cfg.prop_gain) * err
               + longint'(ctl_cfg.deriv_gain) * (err - longint'(prev_err))) >>> FRAC_BITS;
        step = longint'(ctl_cfg.slew_step);
        pwr  = longint'(power_q);
        gap  = raw - pwr;
        if (gap > step)
            pwr = pwr + step;
        else if (gap < -step)
            pwr = pwr - step;
        else
            pwr = raw;
        prev_err = err[ERR_W-1:0];
        lim = longint'(ctl_cfg.power_limit) << FRAC_BITS;
        if (pwr > lim)
            pwr = lim;
        if (pwr < -lim)
            pwr = -lim;
        power_q = pwr[POWER_W-1:0];
        // signed divide truncates toward zero
        whole = pwr / (longint'(1) << FRAC_BITS);
        w.drive       = whole[DRIVE_W-1:0];
        w.angle_error = err[ERR_W-1:0];
        due_commands.push_back(w);
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic logic signed [POS_BITS-1:0] pick_edge();
        case ($urandom_range(0, 3))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic pos_pair_t roll_pair();
        pos_pair_t pr;
        int kind;
        int span;
        int delta;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            pr.first  = POS_BITS'($urandom);
            pr.second = POS_BITS'($urandom);
        end
        else if (kind == 2)
        begin
            pr.first  = pick_edge();
            pr.second = pick_edge();
        end
        else
        begin
            // smooth arm motion, now and then a jump
            span  = ($urandom_range(0, 7) == 0) ? 5000 : 60;
            delta = int'($urandom_range(0, 2 * span)) - span;
            walk_first = walk_first + POS_BITS'(delta);
            delta = int'($urandom_range(0, 2 * span)) - span;
            walk_second = walk_second + POS_BITS'(delta);
            pr.first  = walk_first;
            pr.second = walk_second;
        end
        return pr;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        apply_cfg(idx, val);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic queue_pair(input logic signed [POS_BITS-1:0] a,
                              input logic signed [POS_BITS-1:0] b);
        pos_pair_t pr;
        pr.first  = a;
        pr.second = b;
        pos_backlog.push_back(pr);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pos_backlog.size() != 0 || sample_ch.valid || due_commands.size() != 0);
    endtask

    task automatic load_setting(input int phase);
        case (phase)
            0:
            begin
                write_reg(REG_TARGET_ANGLE, 0);
                write_reg(REG_PROP_GAIN, 72);
                write_reg(REG_DERIV_GAIN, 96);
                write_reg(REG_SLEW_STEP, 128);
                write_reg(REG_POWER_LIMIT, 60);
                write_reg(REG_COUNTS_SCALE, 69054);
                write_reg(IDX_SPARE_A, CFG_DATA_W'($urandom));
            end
            1:
            begin
                write_reg(REG_TARGET_ANGLE, {CFG_DATA_W{1'b1}});
                write_reg(REG_PROP_GAIN, {CFG_DATA_W{1'b1}});
                write_reg(REG_DERIV_GAIN, {CFG_DATA_W{1'b1}});
                write_reg(REG_SLEW_STEP, {CFG_DATA_W{1'b1}});
                write_reg(REG_POWER_LIMIT, {CFG_DATA_W{1'b1}});
                write_reg(REG_COUNTS_SCALE, {CFG_DATA_W{1'b1}});
                write_reg(IDX_SPARE_B, '0);
            end
            2:
            begin
                write_reg(REG_TARGET_ANGLE, 0);
                write_reg(REG_PROP_GAIN, 0);
                write_reg(REG_DERIV_GAIN, 0);
                write_reg(REG_SLEW_STEP, 0);
                write_reg(REG_POWER_LIMIT, 0);
                write_reg(REG_COUNTS_SCALE, 0);
            end
            3:
            begin
                write_reg(REG_TARGET_ANGLE, 5759);
                write_reg(REG_PROP_GAIN, 1023);
                write_reg(REG_DERIV_GAIN, 0);
                write_reg(REG_SLEW_STEP, 1);
                write_reg(REG_POWER_LIMIT, 127);
                write_reg(REG_COUNTS_SCALE, 65536);
            end
            default:
            begin
                write_reg(REG_TARGET_ANGLE, CFG_DATA_W'($urandom));
                write_reg(REG_PROP_GAIN, CFG_DATA_W'($urandom));
                write_reg(REG_DERIV_GAIN, CFG_DATA_W'($urandom));
                write_reg(REG_SLEW_STEP,
                          CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom));
                write_reg(REG_POWER_LIMIT, CFG_DATA_W'($urandom));
                write_reg(REG_COUNTS_SCALE, CFG_DATA_W'($urandom));
                write_reg(($urandom_range(0, 1) == 0) ? IDX_SPARE_A : IDX_SPARE_B,
                          CFG_DATA_W'($urandom));
            end
        endcase
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid      <= 1'b0;
            sample_ch.pos_first  <= '0;
            sample_ch.pos_second <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                predict_drive(sample_ch.pos_first, sample_ch.pos_second);
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pos_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    next_pos = pos_backlog.pop_front();
                    sample_ch.valid      <= 1'b1;
                    sample_ch.pos_first  <= next_pos.first;
                    sample_ch.pos_second <= next_pos.second;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= 0;
        end
        else
        begin
            if (hold_req)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            result_ch.ready <= !hold_req && hold_left <= 1
                               && $urandom_range(0, 99) >= snk_idle_pct;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_commands.size() == 0)
                flag_mismatch($sformatf("unexpected word drive %0d error %0d",
                                        result_ch.drive, result_ch.angle_error));
            else
            begin
                want = due_commands.pop_front();
                checked_words++;
                if (result_ch.drive !== want.drive)
                    flag_mismatch($sformatf("word %0d drive expected %0d got %0d",
                                            checked_words, want.drive, result_ch.drive));
                if (result_ch.angle_error !== want.angle_error)
                    flag_mismatch($sformatf("word %0d angle_error expected %0d got %0d",
                                            checked_words, want.angle_error,
                                            result_ch.angle_error));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("pd_angle_controller_slew regression: fail");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = '0;
        wr_data              = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.pos_first  = '0;
        sample_ch.pos_second = '0;
        result_ch.ready      = 1'b0;
        hold_req             = 1'b0;
        src_idle_pct         = 8;
        snk_idle_pct         = 71;
        checked_words        = 0;
        mismatch_count       = 0;
        walk_first           = '0;
        walk_second          = '0;
        ctl_cfg              = CFG_AT_RESET;
        prev_err             = '0;
        power_q              = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, field extremes and negative flooring
        queue_pair(0, 0);
        queue_pair(POS_MAX, POS_MAX);
        queue_pair(POS_MIN, POS_MIN);
        queue_pair(POS_MAX, POS_MIN);
        queue_pair(-1, 0);
        queue_pair(1, 0);
        queue_pair(0, -1);
        queue_pair(POS_MIN, 0);
        queue_pair(100, -300);
        queue_pair(3000, 2000);
        wait_drained();

        // unit scale: angle equals the sum, hits both wrap edges
        write_reg(REG_COUNTS_SCALE, 65536);
        write_reg(REG_TARGET_ANGLE, 0);
        queue_pair(2879, 0);
        queue_pair(2880, 0);
        queue_pair(2881, 0);
        queue_pair(5759, 0);
        queue_pair(5760, 0);
        queue_pair(-1, 0);
        queue_pair(-2880, 0);
        queue_pair(-2881, 0);
        queue_pair(-5761, 0);
        queue_pair(4320, 4320);
        queue_pair(0, 1);
        queue_pair(0, 0);
        wait_drained();

        // target past a full turn
        write_reg(REG_TARGET_ANGLE, 8191);
        queue_pair(0, 0);
        queue_pair(100, 0);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < 3)
            begin
                src_idle_pct = 8;
                snk_idle_pct = 71;
            end
            else if (phase < 6)
            begin
                src_idle_pct = 71;
                snk_idle_pct = 8;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            load_setting(phase);
            if ($urandom_range(0, 1) == 0)
            begin
                walk_first  = '0;
                walk_second = '0;
            end
            for (int n = 0; n < ((phase == 2) ? 60 : 230); n++)
                pos_backlog.push_back(roll_pair());
            if (phase == 1)
            begin
                // stall the output long enough to back up the input
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (due_commands.size() != 0)
            flag_mismatch($sformatf("%0d words never arrived", due_commands.size()));

        $display("checked %0d control words: directed wrap and extreme cases, then %0d settings",
                 checked_words, PHASE_COUNT);
        $display("random stalls on both sides plus one %0d-cycle output hold-off; %0d mismatches",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("pd_angle_controller_slew regression: pass");
        else
            $display("pd_angle_controller_slew regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pdas_pkg.sv
rtl/pdas_in_if.sv
rtl/pdas_out_if.sv
rtl/pdas_front.sv
rtl/pdas_fifo.sv
rtl/pdas_modred.sv
rtl/pdas_back.sv
rtl/pd_angle_controller_slew.sv
tb/tb_pd_angle_controller_slew.sv
